/* hdl/calendar_day_counter_defines.svh */
// assertion macros for the calendar day counter
// used by the datapath; needs signals aclk and aresetn in scope
`ifndef CALENDAR_DAY_COUNTER_DEFINES_SVH
`define CALENDAR_DAY_COUNTER_DEFINES_SVH

// condition that holds at every edge out of reset
`define CDCNT_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequence in the same cycle
`define CDCNT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the next cycle
`define CDCNT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cdcnt_pkg.sv */
// shared types, constants, microcode codes and calendar helpers
// for the calendar day counter; no dependencies
package cdcnt_pkg;

    // calendar span
    localparam int SPAN_YEARS = 128;
    localparam logic [11:0] BASE_YEAR = 12'd1980;
    localparam int SPAN_DAYS = SPAN_YEARS * 365 + (SPAN_YEARS + 3) / 4;

    // datapath widths
    localparam int YOFF_W = $clog2(SPAN_YEARS);
    localparam int YC_W = $clog2(SPAN_YEARS + 1);
    localparam int ACC_MIN_W = $clog2(SPAN_DAYS + 1);
    localparam int ACC_W = (ACC_MIN_W > 16) ? ACC_MIN_W : 16;
    localparam logic [ACC_W-1:0] SPAN_DAYS_C = ACC_W'(SPAN_DAYS);
    localparam logic [YC_W-1:0] SPAN_YEARS_C = YC_W'(SPAN_YEARS);

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // input word and result word
    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [15:0] set_day_number;
    } cdcnt_in_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] day_number;
        logic        first_of_month;
        logic        first_of_year;
        logic [1:0]  error;
    } cdcnt_out_t;

    // request codes
    typedef enum logic [1:0] {
        ACT_TICK       = 2'd0,
        ACT_SET_DATE   = 2'd1,
        ACT_SET_NUMBER = 2'd2,
        ACT_UNUSED     = 2'd3
    } action_t;

    // result error codes
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_RANGE   = 2'd2
    } err_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_TICK,
        OP_INIT_DATE,
        OP_ADD_YEAR,
        OP_ADD_MONTH,
        OP_COMMIT_DATE,
        OP_INIT_NUM,
        OP_SUB_YEAR,
        OP_SUB_MONTH,
        OP_COMMIT_NUM
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_TICK_LAST,
        C_DATE_BAD,
        C_DATE_FAR,
        C_YEAR_HIT,
        C_MONTH_HIT,
        C_NUM_FAR,
        C_YEAR_END,
        C_MONTH_END
    } cond_t;

    // program addresses
    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t PC_IDLE      = 5'd0;
    localparam pc_t PC_FIN_OK    = 5'd1;
    localparam pc_t PC_FIN_INV   = 5'd2;
    localparam pc_t PC_FIN_RANGE = 5'd3;
    localparam pc_t PC_TICK      = 5'd4;
    localparam pc_t PC_TICK_END  = 5'd5;
    localparam pc_t PC_DATE_CHK  = 5'd6;
    localparam pc_t PC_DATE_FAR  = 5'd7;
    localparam pc_t PC_DATE_YRS  = 5'd8;
    localparam pc_t PC_DATE_MON  = 5'd9;
    localparam pc_t PC_DATE_SET  = 5'd10;
    localparam pc_t PC_DATE_END  = 5'd11;
    localparam pc_t PC_NUM_CHK   = 5'd12;
    localparam pc_t PC_NUM_YRS   = 5'd13;
    localparam pc_t PC_NUM_MON   = 5'd14;
    localparam pc_t PC_NUM_SET   = 5'd15;
    localparam pc_t PC_NUM_END   = 5'd16;

    // one control word of the program
    typedef struct packed {
        logic  dispatch;
        logic  done;
        logic  hold;
        err_t  err;
        cond_t cond;
        op_t   op;
        pc_t   target;
    } cdcnt_cw_t;

    // sequencer to datapath
    typedef struct packed {
        logic load_in;
        op_t  op;
        logic emit;
        err_t err;
    } cdcnt_ctl_t;

    // datapath to sequencer
    typedef struct packed {
        logic tick_last;
        logic date_bad;
        logic date_far;
        logic year_hit;
        logic month_hit;
        logic num_far;
        logic year_end;
        logic month_end;
        logic out_free;
    } cdcnt_status_t;

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [3:0] idx;
        idx = m - 4'd1;
        if (m < 4'd1 || m > 4'd12) begin
            return 5'd0;
        end
        if (m == 4'd2 && leap) begin
            return 5'd29;
        end
        return MONTH_DAYS[idx];
    endfunction

    // entry point of each request routine
    function automatic pc_t dispatch_target(input logic [1:0] action);
        case (action)
            ACT_TICK:       return PC_TICK;
            ACT_SET_DATE:   return PC_DATE_CHK;
            ACT_SET_NUMBER: return PC_NUM_CHK;
            default:        return PC_FIN_INV;
        endcase
    endfunction

endpackage

/* hdl/cdcnt_ucode_rom.sv */
// control store of the calendar day counter: one control word per step
// depends on cdcnt_pkg
module cdcnt_ucode_rom (
    input  cdcnt_pkg::pc_t      pc,
    output cdcnt_pkg::cdcnt_cw_t cw
);
    import cdcnt_pkg::*;

    function automatic cdcnt_cw_t word(input logic dsp, input logic dn, input logic hld,
                                       input err_t e, input cond_t c, input op_t o,
                                       input pc_t t);
        cdcnt_cw_t w;
        w.dispatch = dsp;
        w.done     = dn;
        w.hold     = hld;
        w.err      = e;
        w.cond     = c;
        w.op       = o;
        w.target   = t;
        return w;
    endfunction

    // program listing
    always_comb begin
        case (pc)
            PC_IDLE:      cw = word(1'b1, 1'b0, 1'b0, ERR_NONE, C_NEVER, OP_NOP, PC_IDLE);
            PC_FIN_OK:    cw = word(1'b0, 1'b1, 1'b0, ERR_NONE, C_NEVER, OP_NOP, PC_IDLE);
            PC_FIN_INV:   cw = word(1'b0, 1'b1, 1'b0, ERR_INVALID, C_NEVER, OP_NOP, PC_IDLE);
            PC_FIN_RANGE: cw = word(1'b0, 1'b1, 1'b0, ERR_RANGE, C_NEVER, OP_NOP, PC_IDLE);
            // tick one day
            PC_TICK:      cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_TICK_LAST, OP_TICK,
                                    PC_FIN_RANGE);
            PC_TICK_END:  cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_ALWAYS, OP_NOP, PC_FIN_OK);
            // set by date: check, then sum whole years and whole months
            PC_DATE_CHK:  cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_DATE_BAD, OP_INIT_DATE,
                                    PC_FIN_INV);
            PC_DATE_FAR:  cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_DATE_FAR, OP_NOP,
                                    PC_FIN_RANGE);
            PC_DATE_YRS:  cw = word(1'b0, 1'b0, 1'b1, ERR_NONE, C_YEAR_HIT, OP_ADD_YEAR,
                                    PC_DATE_MON);
            PC_DATE_MON:  cw = word(1'b0, 1'b0, 1'b1, ERR_NONE, C_MONTH_HIT, OP_ADD_MONTH,
                                    PC_DATE_SET);
            PC_DATE_SET:  cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_NEVER, OP_COMMIT_DATE,
                                    PC_IDLE);
            PC_DATE_END:  cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_ALWAYS, OP_NOP, PC_FIN_OK);
            // set by day number: check the range, then peel off years, then months
            PC_NUM_CHK:   cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_NUM_FAR, OP_INIT_NUM,
                                    PC_FIN_RANGE);
            PC_NUM_YRS:   cw = word(1'b0, 1'b0, 1'b1, ERR_NONE, C_YEAR_END, OP_SUB_YEAR,
                                    PC_NUM_MON);
            PC_NUM_MON:   cw = word(1'b0, 1'b0, 1'b1, ERR_NONE, C_MONTH_END, OP_SUB_MONTH,
                                    PC_NUM_SET);
            PC_NUM_SET:   cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_NEVER, OP_COMMIT_NUM,
                                    PC_IDLE);
            PC_NUM_END:   cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_ALWAYS, OP_NOP, PC_FIN_OK);
            default:      cw = word(1'b0, 1'b0, 1'b0, ERR_NONE, C_ALWAYS, OP_NOP, PC_IDLE);
        endcase
    end

endmodule

/* hdl/cdcnt_sequencer.sv */
// step counter with conditional jumps and request dispatch
// depends on cdcnt_pkg and cdcnt_ucode_rom
module cdcnt_sequencer (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               action,
    input  cdcnt_pkg::cdcnt_status_t status,
    output cdcnt_pkg::cdcnt_ctl_t    ctl
);
    import cdcnt_pkg::*;

    pc_t       pc_reg;
    pc_t       pc_next;
    cdcnt_cw_t cw;
    logic      taken;

    cdcnt_ucode_rom u_rom (
        .pc (pc_reg),
        .cw (cw)
    );

    // jump condition select
    always_comb begin
        case (cw.cond)
            C_NEVER:     taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_TICK_LAST: taken = status.tick_last;
            C_DATE_BAD:  taken = status.date_bad;
            C_DATE_FAR:  taken = status.date_far;
            C_YEAR_HIT:  taken = status.year_hit;
            C_MONTH_HIT: taken = status.month_hit;
            C_NUM_FAR:   taken = status.num_far;
            C_YEAR_END:  taken = status.year_end;
            C_MONTH_END: taken = status.month_end;
            default:     taken = 1'b1;
        endcase
    end

    // next step and control to the datapath
    always_comb begin
        pc_next     = pc_reg;
        s_ready     = 1'b0;
        ctl.load_in = 1'b0;
        ctl.op      = OP_NOP;
        ctl.emit    = 1'b0;
        ctl.err     = cw.err;
        if (cw.dispatch) begin
            s_ready = 1'b1;
            if (s_valid) begin
                ctl.load_in = 1'b1;
                pc_next     = dispatch_target(action);
            end
        end else if (cw.done) begin
            if (status.out_free) begin
                ctl.emit = 1'b1;
                pc_next  = PC_IDLE;
            end
        end else if (taken) begin
            pc_next = cw.target;
        end else begin
            ctl.op  = cw.op;
            pc_next = cw.hold ? pc_reg : pc_reg + 1'b1;
        end
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hdl/cdcnt_datapath.sv */
// date registers, conversion accumulator, loop counters and result register
// depends on cdcnt_pkg and calendar_day_counter_defines.svh
`include "calendar_day_counter_defines.svh"
module cdcnt_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cdcnt_pkg::cdcnt_in_t     s_data,
    input  cdcnt_pkg::cdcnt_ctl_t    ctl,
    output cdcnt_pkg::cdcnt_status_t status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output cdcnt_pkg::cdcnt_out_t    m_data
);
    import cdcnt_pkg::*;

    cdcnt_in_t         in_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [YC_W-1:0]   yc_reg, yc_next;
    logic [3:0]        mc_reg, mc_next;
    logic [YOFF_W-1:0] yoff_reg, yoff_next;
    logic [3:0]        mon_reg, mon_next;
    logic [4:0]        day_reg, day_next;
    logic [ACC_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg;
    cdcnt_out_t        m_data_reg;

    logic [11:0]       ydiff;
    logic              yc_leap;
    logic              now_leap;
    logic [8:0]        yc_ylen;
    logic [4:0]        yc_mlen;
    logic [4:0]        now_mlen;
    logic [ACC_W-1:0]  num_ext;

    // shared decode of the loop position, the stored date and the request
    always_comb begin
        ydiff    = in_reg.set_year - BASE_YEAR;
        yc_leap  = (yc_reg[1:0] == 2'b00);
        now_leap = (yoff_reg[1:0] == 2'b00);
        yc_ylen  = year_len(yc_leap);
        yc_mlen  = month_len(yc_leap, mc_reg);
        now_mlen = month_len(now_leap, mon_reg);
        num_ext  = ACC_W'(in_reg.set_day_number);
    end

    // jump conditions
    always_comb begin
        status.tick_last = (cnt_reg >= SPAN_DAYS_C - ACC_W'(1));
        status.date_bad  = (in_reg.set_year < BASE_YEAR) || (in_reg.set_month < 4'd1)
                         || (in_reg.set_month > 4'd12) || (in_reg.set_day == 5'd0)
                         || (in_reg.set_day > month_len(ydiff[1:0] == 2'b00,
                                                       in_reg.set_month));
        status.date_far  = (ydiff >= 12'(SPAN_YEARS));
        status.year_hit  = (yc_reg == ydiff[YC_W-1:0]);
        status.month_hit = (mc_reg == in_reg.set_month);
        status.num_far   = (num_ext >= SPAN_DAYS_C);
        status.year_end  = !((yc_reg < SPAN_YEARS_C) && (acc_reg >= ACC_W'(yc_ylen)));
        status.month_end = !((mc_reg < 4'd12) && (acc_reg >= ACC_W'(yc_mlen)));
        status.out_free  = !m_valid_reg || m_ready;
    end

    // datapath operations
    always_comb begin
        acc_next  = acc_reg;
        yc_next   = yc_reg;
        mc_next   = mc_reg;
        yoff_next = yoff_reg;
        mon_next  = mon_reg;
        day_next  = day_reg;
        cnt_next  = cnt_reg;
        case (ctl.op)
            OP_TICK: begin
                cnt_next = cnt_reg + ACC_W'(1);
                if (day_reg >= now_mlen) begin
                    day_next = 5'd1;
                    if (mon_reg >= 4'd12) begin
                        mon_next  = 4'd1;
                        yoff_next = yoff_reg + YOFF_W'(1);
                    end else begin
                        mon_next = mon_reg + 4'd1;
                    end
                end else begin
                    day_next = day_reg + 5'd1;
                end
            end
            OP_INIT_DATE: begin
                acc_next = '0;
                yc_next  = '0;
                mc_next  = 4'd1;
            end
            OP_ADD_YEAR: begin
                acc_next = acc_reg + ACC_W'(yc_ylen);
                yc_next  = yc_reg + YC_W'(1);
            end
            OP_ADD_MONTH: begin
                acc_next = acc_reg + ACC_W'(yc_mlen);
                mc_next  = mc_reg + 4'd1;
            end
            OP_COMMIT_DATE: begin
                yoff_next = ydiff[YOFF_W-1:0];
                mon_next  = in_reg.set_month;
                day_next  = in_reg.set_day;
                cnt_next  = acc_reg + ACC_W'(in_reg.set_day) - ACC_W'(1);
            end
            OP_INIT_NUM: begin
                acc_next = num_ext;
                yc_next  = '0;
                mc_next  = 4'd1;
            end
            OP_SUB_YEAR: begin
                acc_next = acc_reg - ACC_W'(yc_ylen);
                yc_next  = yc_reg + YC_W'(1);
            end
            OP_SUB_MONTH: begin
                acc_next = acc_reg - ACC_W'(yc_mlen);
                mc_next  = mc_reg + 4'd1;
            end
            OP_COMMIT_NUM: begin
                yoff_next = yc_reg[YOFF_W-1:0];
                mon_next  = mc_reg;
                day_next  = acc_reg[4:0] + 5'd1;
                cnt_next  = num_ext;
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    // date state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yoff_reg <= '0;
            mon_reg  <= 4'd1;
            day_reg  <= 5'd1;
            cnt_reg  <= '0;
        end else begin
            yoff_reg <= yoff_next;
            mon_reg  <= mon_next;
            day_reg  <= day_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers and captured request
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        yc_reg  <= yc_next;
        mc_reg  <= mc_next;
        if (ctl.load_in) begin
            in_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            m_data_reg.year           <= BASE_YEAR + 12'(yoff_reg);
            m_data_reg.month          <= mon_reg;
            m_data_reg.day            <= day_reg;
            m_data_reg.day_number     <= cnt_reg[15:0];
            m_data_reg.first_of_month <= (day_reg == 5'd1);
            m_data_reg.first_of_year  <= (day_reg == 5'd1) && (mon_reg == 4'd1);
            m_data_reg.error          <= ctl.err;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `CDCNT_ASSERT_ALWAYS(a_date_legal, (mon_reg >= 4'd1) && (mon_reg <= 4'd12) && (day_reg != 5'd0), "stored date out of range")
    `CDCNT_ASSERT_ALWAYS(a_count_in_span, cnt_reg < SPAN_DAYS_C, "day number beyond span")
    `CDCNT_ASSERT_NEXT(a_tick_count, ctl.op == OP_TICK, cnt_reg == $past(cnt_reg) + ACC_W'(1), "tick did not advance day number")
    `CDCNT_ASSERT_NEXT(a_emit_matches, ctl.emit, m_valid_reg && (m_data_reg.day_number == cnt_reg[15:0]), "result does not match stored state")
    `CDCNT_ASSERT_IMPLY(a_emit_free, ctl.emit, !m_valid_reg || m_ready, "result overwritten before taken")

endmodule

/* hdl/calendar_day_counter.sv */
// top level of the calendar day counter: microcoded sequencer and datapath
// depends on cdcnt_pkg, cdcnt_sequencer, cdcnt_datapath
//
//   channel   ports                      word
//   input     s_valid s_ready s_data     request: tick, set by date, set by day number
//   result    m_valid m_ready m_data     date, day number, flags and error code
//
// one request at a time; a tick steps through PC_TICK, PC_TICK_END and PC_FIN_OK
// before its result is registered; set by date checks the date and range, then
// adds whole years and months, set by day number checks the range, then subtracts
// them; error exits are shorter; the year loop of the shared accumulator sets their length
// reset (aresetn low, synchronous) gives 1980-01-01, day number 0
// a result waiting on m_ready does not block acceptance of the next request
module calendar_day_counter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cdcnt_pkg::cdcnt_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cdcnt_pkg::cdcnt_out_t m_data
);
    import cdcnt_pkg::*;

    cdcnt_ctl_t    ctl;
    cdcnt_status_t status;

    // program sequencer
    cdcnt_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .action  (s_data.action),
        .status  (status),
        .ctl     (ctl)
    );

    // registers and arithmetic
    cdcnt_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctl     (ctl),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
